// ----- hdl/pmmd_pkg.sv -----
package pmmd_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 32;
    localparam int unsigned SampleW  = 16;
    localparam int unsigned CountW   = 32;
    localparam int unsigned RateW    = 17;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SAMPLE_DEPTH = 3'd0,
        CFG_STEREO       = 3'd1,
        CFG_HALVE        = 3'd2,
        CFG_SAMPLE_RATE  = 3'd3,
        CFG_SAMPLE_LIMIT = 3'd4
    } cfg_idx_t;

    localparam logic [RateW-1:0] HALVE_RATE_MIN  = 17'd32000;
    localparam logic [RateW-1:0] RATE_RESET      = 17'd44100;

    typedef logic signed [SampleW-1:0] sample_t;

    // (a + b) / 2 rounded toward zero, as in C integer division.
    function automatic sample_t avg_trunc(input sample_t a, input sample_t b);
        logic signed [SampleW:0] sum;
        logic signed [SampleW:0] adj;
        sum = {a[SampleW-1], a} + {b[SampleW-1], b};
        adj = sum + {{SampleW{1'b0}}, sum[SampleW]};
        return adj[SampleW:1];
    endfunction

endpackage

// ----- hdl/pmmd_lane.sv -----
module pmmd_lane
    import pmmd_pkg::*;
(
    input  logic       depth16,
    input  logic [7:0] byte_8b,
    input  logic [7:0] byte_lo,
    input  logic [7:0] byte_hi,
    output sample_t    value
);

    // 8-bit: unsigned minus 128 is the byte with its top bit flipped.
    always_comb begin
        if (depth16) begin
            value = {byte_hi, byte_lo};
        end else begin
            value = {{(SampleW-7){~byte_8b[7]}}, byte_8b[6:0]};
        end
    end

endmodule

// ----- hdl/pmmd_mix.sv -----
module pmmd_mix
    import pmmd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    stereo,
    input  logic    in_valid,
    output logic    in_ready,
    input  sample_t left,
    input  sample_t right,
    output logic    out_valid,
    input  logic    out_ready,
    output sample_t out_value
);

    logic    valid_reg, valid_next;
    sample_t value_reg, value_next;

    always_comb begin
        in_ready   = !valid_reg || out_ready;
        valid_next = valid_reg && !out_ready;
        value_next = value_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
            value_next = stereo ? avg_trunc(left, right) : left;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;

endmodule

// ----- hdl/pmmd_out.sv -----
module pmmd_out
    import pmmd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pairing,
    input  logic [CountW-1:0] limit,
    input  logic              in_valid,
    output logic              in_ready,
    input  sample_t           in_value,
    output logic              m_valid,
    input  logic              m_ready,
    output sample_t           m_sample,
    output logic              m_last,
    output logic [CountW-1:0] m_count
);

    logic              phase_reg, phase_next;
    sample_t           held_reg, held_next;
    logic [CountW-1:0] cnt_reg, cnt_next;
    logic              valid_reg, valid_next;
    sample_t           sample_reg, sample_next;
    logic              last_reg, last_next;
    logic [CountW-1:0] ocnt_reg, ocnt_next;
    logic [CountW-1:0] cnt_inc;

    always_comb begin
        in_ready    = !valid_reg || m_ready;
        cnt_inc     = cnt_reg + 1'b1;
        phase_next  = phase_reg;
        held_next   = held_reg;
        cnt_next    = cnt_reg;
        valid_next  = valid_reg && !m_ready;
        sample_next = sample_reg;
        last_next   = last_reg;
        ocnt_next   = ocnt_reg;
        // past the limit a request is swallowed with no state change
        if (in_valid && in_ready && (cnt_reg < limit)) begin
            if (pairing && !phase_reg) begin
                held_next  = in_value;
                phase_next = 1'b1;
            end else begin
                phase_next  = 1'b0;
                cnt_next    = cnt_inc;
                valid_next  = 1'b1;
                sample_next = pairing ? avg_trunc(held_reg, in_value) : in_value;
                last_next   = (cnt_inc == limit);
                ocnt_next   = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            held_reg  <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
        sample_reg <= sample_next;
        last_reg   <= last_next;
        ocnt_reg   <= ocnt_next;
    end

    assign m_valid  = valid_reg;
    assign m_sample = sample_reg;
    assign m_last   = last_reg;
    assign m_count  = ocnt_reg;

endmodule

// ----- hdl/pcm_mono_mixdown_decimator.sv -----
// Channel  | Dir | Ports                     | Contents
// ---------+-----+---------------------------+-----------------------------------------
// frames   | in  | s_tvalid/s_tready/s_tdata | byte0..byte3, one PCM frame per request
// samples  | out | m_tvalid/m_tready/m_tdata | sample, sample_count; m_tlast=limit_reached
// config   | in  | cfg_wr_en/cfg_index/cfg_data | register write, no read-back
//
// One frame per cycle sustained while m_tready stays high; a sample passes the mix register, then the output register.
// Rate is set by the pairing/count update in the output stage, one frame a cycle.
// Reset (aresetn low, synchronous) restores register defaults and clears the
// held frame, pair phase and sample count. Stalls on m_tready propagate back
// through both stages; each stage still takes a new request while it hands off.
module pcm_mono_mixdown_decimator
    import pmmd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // config write port
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    // frame input
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // [7:0] byte0, [15:8] byte1, [23:16] byte2, [31:24] byte3
    // sample output
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,   // [15:0] sample, [47:16] sample_count
    output logic                m_tlast    // limit_reached
);

    // configuration registers
    logic              depth_reg;
    logic              stereo_reg;
    logic              halve_reg;
    logic [RateW-1:0]  rate_reg;
    logic [CountW-1:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg  <= 1'b1;
            stereo_reg <= 1'b0;
            halve_reg  <= 1'b0;
            rate_reg   <= RATE_RESET;
            limit_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SAMPLE_DEPTH: depth_reg  <= cfg_data[0];
                CFG_STEREO:       stereo_reg <= cfg_data[0];
                CFG_HALVE:        halve_reg  <= cfg_data[0];
                CFG_SAMPLE_RATE:  rate_reg   <= cfg_data[RateW-1:0];
                CFG_SAMPLE_LIMIT: limit_reg  <= cfg_data[CountW-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // decimate only when asked and the source rate is high enough
    logic pairing;
    assign pairing = halve_reg && (rate_reg > HALVE_RATE_MIN);

    // two decode lanes: left always from byte0/byte1; right from byte1 (8-bit)
    // or byte2/byte3 (16-bit)
    sample_t left_val, right_val;

    pmmd_lane u_lane_left (
        .depth16 (depth_reg),
        .byte_8b (s_tdata[7:0]),
        .byte_lo (s_tdata[7:0]),
        .byte_hi (s_tdata[15:8]),
        .value   (left_val)
    );

    pmmd_lane u_lane_right (
        .depth16 (depth_reg),
        .byte_8b (s_tdata[15:8]),
        .byte_lo (s_tdata[23:16]),
        .byte_hi (s_tdata[31:24]),
        .value   (right_val)
    );

    // stage 1: stereo mixdown, registered
    logic    mix_valid, mix_ready;
    sample_t mix_value;

    pmmd_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stereo    (stereo_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .left      (left_val),
        .right     (right_val),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .out_value (mix_value)
    );

    // stage 2: frame pairing, limit check, count and output register
    sample_t           out_sample;
    logic [CountW-1:0] out_count;

    pmmd_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pairing  (pairing),
        .limit    (limit_reg),
        .in_valid (mix_valid),
        .in_ready (mix_ready),
        .in_value (mix_value),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_sample (out_sample),
        .m_last   (m_tlast),
        .m_count  (out_count)
    );

    assign m_tdata = {out_count, out_sample};

endmodule

// ----- sim/pcm_mono_mixdown_decimator_tb.sv -----
`timescale 1ns / 100ps

module pcm_mono_mixdown_decimator_tb;
    import pmmd_pkg::*;

    localparam int PCM_BIAS      = 128;    // unsigned 8-bit offset
    localparam int DRAIN_CYCLES  = 8;      // margin on top of the block latency
    localparam int TARGET_FRAMES = 1900;   // frames accepted by the block, ignored ones too
    localparam int HOLD_CYCLES   = 300;    // long receiver back-pressure stretch

    // One expected output sample, fields as they come back on m_tdata/m_tlast.
    typedef struct packed {
        sample_t           value;
        logic              last;
        logic [CountW-1:0] count;
    } sample_rec_t;

    // Predicts the mixdown/decimation and checks samples in arrival order.
    class mixdown_scoreboard;
        bit                depth16;
        bit                stereo;
        bit                halve;
        bit [RateW-1:0]    rate;
        bit [CountW-1:0]   limit;
        int                held;
        bit                phase;
        bit [CountW-1:0]   count;
        sample_rec_t       pending_samples[$];
        int                fails;
        int                frames;
        int                ignored;
        int                samples;
        int                flags;

        function void reset_state();
            depth16 = 1'b1;
            stereo  = 1'b0;
            halve   = 1'b0;
            rate    = RATE_RESET;
            limit   = '0;
            held    = 0;
            phase   = 1'b0;
            count   = '0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
            case (idx)
                CFG_SAMPLE_DEPTH: depth16 = val[0];
                CFG_STEREO:       stereo  = val[0];
                CFG_HALVE:        halve   = val[0];
                CFG_SAMPLE_RATE:  rate    = val[RateW-1:0];
                CFG_SAMPLE_LIMIT: limit   = val[CountW-1:0];
                default: ;
            endcase
        endfunction

        // Returns 1 when the frame was used (emitted or held), 0 when past the limit.
        function bit note_frame(logic [31:0] d);
            int          v;
            bit          pairing;
            sample_rec_t rec;
            frames++;
            if (count >= limit) begin
                ignored++;
                return 1'b0;
            end
            if (!depth16) begin
                v = int'(d[7:0]) - PCM_BIAS;
                if (stereo)
                    v = (v + int'(d[15:8]) - PCM_BIAS) / 2;
            end else begin
                v = int'($signed(d[15:0]));
                if (stereo)
                    v = (v + int'($signed(d[31:16]))) / 2;
            end
            pairing = halve && (rate > HALVE_RATE_MIN);
            if (pairing) begin
                if (!phase) begin
                    held  = v;
                    phase = 1'b1;
                    return 1'b1;
                end
                v = (held + v) / 2;
            end
            phase = 1'b0;
            count = count + 1;
            rec.value = v[SampleW-1:0];
            rec.last  = (count == limit);
            rec.count = count;
            pending_samples.push_back(rec);
            return 1'b1;
        endfunction

        function void check_sample(logic [47:0] d, logic last);
            sample_rec_t want;
            if (pending_samples.size() == 0) begin
                fails++;
                $display("%0t: unexpected sample %0d count %0d", $time,
                         $signed(d[15:0]), d[47:16]);
                return;
            end
            want = pending_samples.pop_front();
            samples++;
            if (last)
                flags++;
            if (d[15:0] !== want.value) begin
                fails++;
                $display("%0t: sample expected %0d actual %0d", $time,
                         want.value, $signed(d[15:0]));
            end
            if (d[47:16] !== want.count) begin
                fails++;
                $display("%0t: sample_count expected %0d actual %0d", $time,
                         want.count, d[47:16]);
            end
            if (last !== want.last) begin
                fails++;
                $display("%0t: limit_reached expected %0b actual %0b", $time,
                         want.last, last);
            end
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata   = '0;   // [7:0] byte0, [15:8] byte1, [23:16] byte2, [31:24] byte3
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [47:0]         m_tdata;          // [15:0] sample, [47:16] sample_count
    logic                m_tlast;          // limit_reached

    mixdown_scoreboard sb;
    int tx_idle_pct  = 6;    // chance per cycle that the frame source holds back
    int rx_idle_pct  = 81;   // chance per cycle that the sample sink is not ready
    int frames_used  = 0;
    int settings     = 0;
    bit pressure_req = 1'b0;
    logic rx_hold    = 1'b0;

    pcm_mono_mixdown_decimator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Sample sink: random ready, forced low while a long hold is in progress.
    always @(posedge aclk) begin
        if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Every sample request that completes goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_sample(m_tdata, m_tlast);
    end

    // Long back-pressure stretch, counted here, while the source keeps offering
    // frames; the two pipeline stages fill and s_tready must drop.
    initial begin
        wait (pressure_req);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Offers one frame with random idle cycles before it and returns at the
    // edge where the request completes. tvalid stays high into the next call.
    task automatic send_frame(input logic [31:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
            @(posedge aclk);
        while (!s_tready);
        void'(sb.note_frame(d));
        frames_used++;
    endtask

    // Stop offering, wait for every expected sample, then let any frame that
    // produces nothing (a held first half or a dropped one) clear the pipe.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_samples.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // Rewrites every register with the block idle. Junk in the bits above each
    // register's width must be dropped; writes to unused indexes must do nothing.
    task automatic set_mode(input bit d, input bit st, input bit hv,
                            input int unsigned rate, input logic [31:0] lim);
        logic [31:0] junk;
        drain();
        junk = $urandom();
        cfg_write(CFG_SAMPLE_DEPTH, {junk[31:1], d});
        junk = $urandom();
        cfg_write(CFG_STEREO, {junk[31:1], st});
        junk = $urandom();
        cfg_write(CFG_HALVE, {junk[31:1], hv});
        junk = $urandom();
        cfg_write(CFG_SAMPLE_RATE, {($urandom_range(1) ? junk[31:17] : 15'd0), rate[16:0]});
        cfg_write(CFG_SAMPLE_LIMIT, lim);
        if ($urandom_range(3) == 0)
            cfg_write(CfgIdxW'(int'(CFG_SAMPLE_LIMIT) + $urandom_range(3, 1)), $urandom());
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    initial begin
        bit          d;
        bit          st;
        bit          hv;
        int unsigned rate;
        logic [31:0] lim;
        logic [31:0] f;
        int          n;
        bit          squeeze;

        sb = new();
        sb.reset_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset limit is zero: nothing may come out.
        send_frame(32'h1234_5678);
        send_frame(32'h0000_0000);

        // 8-bit mono: bias removal at the byte extremes, upper bytes are junk.
        set_mode(1'b0, 1'b0, 1'b0, 44100, '1);
        send_frame(32'hA5C3_7E00);
        send_frame(32'h5A3C_81FF);
        send_frame(32'hFFFF_FF80);

        // 8-bit stereo: the averages truncate toward zero.
        set_mode(1'b0, 1'b1, 1'b0, 1000, '1);
        send_frame(32'hFFFF_0000);
        send_frame(32'h0000_FFFF);
        send_frame(32'h1234_FF00);
        send_frame(32'h0000_0001);

        // 16-bit mono extremes, bytes 2 and 3 ignored.
        set_mode(1'b1, 1'b0, 1'b0, 96000, '1);
        send_frame(32'hDEAD_8000);
        send_frame(32'hBEEF_7FFF);
        send_frame(32'h0000_FFFF);

        // 16-bit stereo, including a sum of -1 that must round to zero.
        set_mode(1'b1, 1'b1, 1'b0, 44100, '1);
        send_frame(32'h8000_8000);
        send_frame(32'h7FFF_7FFF);
        send_frame(32'h8000_7FFF);
        send_frame(32'h0000_FFFF);

        // Halving requested at exactly 32000: not active, every frame emits.
        set_mode(1'b1, 1'b0, 1'b1, 32000, '1);
        send_frame(32'h0000_4321);

        // Just above: frames pair up; a held first half then sees halving
        // turned off by a register write and is dropped.
        set_mode(1'b1, 1'b0, 1'b1, 32001, '1);
        send_frame(32'h0000_8000);
        send_frame(32'h0000_8001);
        send_frame(32'h0000_0001);
        set_mode(1'b1, 1'b0, 1'b0, 32001, '1);
        send_frame(32'h0000_0002);

        // Limit one sample ahead: that sample is flagged, the rest ignored.
        set_mode(1'b1, 1'b1, 1'b1, 96000, sb.count + 1);
        send_frame(32'h0100_7F00);
        send_frame(32'hF000_0FFF);
        send_frame(32'h1111_2222);

        // Random phases, each with fresh settings and, but for the squeeze, a random frame count.
        while (frames_used < TARGET_FRAMES) begin
            squeeze = 1'b0;
            if (frames_used >= (2 * TARGET_FRAMES) / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                squeeze = !pressure_req;
            end else if (frames_used >= TARGET_FRAMES / 3) begin
                tx_idle_pct = 81;
                rx_idle_pct = 6;
            end else begin
                tx_idle_pct = 6;
                rx_idle_pct = 81;
            end

            d  = $urandom_range(1);
            st = $urandom_range(1);
            hv = ($urandom_range(3) != 0);
            case ($urandom_range(5))
                0:       rate = 1000;
                1:       rate = 32000;
                2:       rate = 32001;
                3:       rate = 96000;
                default: rate = $urandom_range(96000, 1000);
            endcase
            case ($urandom_range(11))
                0:       lim = sb.count + $urandom_range(12, 1);
                1:       lim = sb.count;
                2:       lim = '0;
                3, 4:    lim = sb.count + $urandom_range(5000, 500);
                default: lim = '1;
            endcase
            if (squeeze)
                lim = '1;
            set_mode(d, st, hv, rate, lim);

            n = squeeze ? 80 : $urandom_range(80, 1);
            if (squeeze)
                pressure_req = 1'b1;
            repeat (n) begin
                for (int b = 0; b < 4; b++) begin
                    case ($urandom_range(7))
                        0:       f[b*8 +: 8] = 8'h00;
                        1:       f[b*8 +: 8] = 8'hFF;
                        2:       f[b*8 +: 8] = 8'h80;
                        3:       f[b*8 +: 8] = 8'h7F;
                        default: f[b*8 +: 8] = 8'($urandom_range(255));
                    endcase
                end
                send_frame(f);
            end
        end

        drain();
        $display("Ran %0d frames (%0d past the limit) over %0d register settings;",
                 sb.frames, sb.ignored, settings);
        $display("checked %0d samples, %0d of them flagged as the last one allowed.",
                 sb.samples, sb.flags);
        if (sb.fails == 0 && sb.pending_samples.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #800000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
